[hdl/ids_pkg.sv]
// Shared types, request codes and register map for the interrupt duration statistics block.
package ids_pkg;

  localparam int DEF_NUM_SOURCES = 8;
  localparam int MAX_NUM_SOURCES = 16;
  localparam int MASK_BITS       = 8;
  localparam int STAT_W          = 32;
  localparam int VEC_W           = 4;
  localparam int REQ_W           = 2;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int IN_DATA_W       = 40;
  localparam int OUT_DATA_W      = 4 * STAT_W;

  // Request codes; any other code behaves as a read
  localparam logic [REQ_W-1:0] REQ_ENTER = 2'd0;
  localparam logic [REQ_W-1:0] REQ_EXIT  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  // Register index taken from paddr[2]
  localparam logic REG_ENABLE_MASK = 1'b0;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [VEC_W-1:0]  vector;
    logic [STAT_W-1:0] duration;
  } item_t;

  typedef struct packed {
    logic              accepted;
    logic [STAT_W-1:0] event_count;
    logic [STAT_W-1:0] duration_sum;
    logic [STAT_W-1:0] longest;
    logic [STAT_W-1:0] shortest;
  } result_t;

endpackage

[hdl/ids_apb.sv]
// APB register file holding the source enable mask.
module ids_apb (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [ids_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [ids_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [ids_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready,
  output logic [ids_pkg::MASK_BITS-1:0]     enable_mask
);

  logic [ids_pkg::MASK_BITS-1:0] mask_r;
  logic                          wr_en;
  logic                          sel_mask;

  // Decode the word index; byte offset bits carry no meaning
  assign sel_mask   = (cfg_paddr[2] == ids_pkg::REG_ENABLE_MASK);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Write the mask on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (wr_en && sel_mask) begin
      mask_r <= cfg_pwdata[ids_pkg::MASK_BITS-1:0];
    end
  end

  // Read back the mask, zero elsewhere
  always_comb begin
    cfg_prdata = '0;
    if (sel_mask) begin
      cfg_prdata[ids_pkg::MASK_BITS-1:0] = mask_r;
    end
  end

  assign enable_mask = mask_r;

endmodule

[hdl/ids_stats.sv]
// Per-source statistics table; the selected entry is read and updated combinationally and written back on the clock.
module ids_stats #(
  parameter int NUM_SOURCES = ids_pkg::DEF_NUM_SOURCES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          upd,
  input  ids_pkg::item_t                item,
  input  logic [ids_pkg::MASK_BITS-1:0] enable_mask,
  output ids_pkg::result_t              result
);

  localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

  logic [ids_pkg::STAT_W-1:0] count_r [NUM_SOURCES];
  logic [ids_pkg::STAT_W-1:0] total_r [NUM_SOURCES];
  logic [ids_pkg::STAT_W-1:0] max_r   [NUM_SOURCES];
  logic [ids_pkg::STAT_W-1:0] min_r   [NUM_SOURCES];

  logic [IDX_W-1:0]           idx;
  logic                       in_range;
  logic                       enabled;
  logic                       acc;
  logic [ids_pkg::STAT_W-1:0] cnt_cur, tot_cur, max_cur, min_cur;
  logic [ids_pkg::STAT_W-1:0] cnt_nxt, tot_nxt, max_nxt, min_nxt;

  // Select the entry; sources without a mask bit count as disabled
  assign in_range = ({1'b0, item.vector} < 5'(NUM_SOURCES));
  assign idx      = item.vector[IDX_W-1:0];
  assign enabled  = (item.vector < 4'(ids_pkg::MASK_BITS)) && enable_mask[item.vector[2:0]];
  assign acc      = in_range && enabled;

  assign cnt_cur = count_r[idx];
  assign tot_cur = total_r[idx];
  assign max_cur = max_r[idx];
  assign min_cur = min_r[idx];

  // Compute the updated entry
  always_comb begin
    cnt_nxt = cnt_cur;
    tot_nxt = tot_cur;
    max_nxt = max_cur;
    min_nxt = min_cur;
    if (acc) begin
      case (item.req_type)
        ids_pkg::REQ_ENTER: begin
          cnt_nxt = cnt_cur + 32'd1;
        end
        ids_pkg::REQ_EXIT: begin
          tot_nxt = tot_cur + item.duration;
          if (item.duration > max_cur) begin
            max_nxt = item.duration;
          end
          // A stored shortest of zero is unset and always replaced
          if ((item.duration < min_cur) || (min_cur == '0)) begin
            min_nxt = item.duration;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Write back the entry when an accepted beat advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SOURCES; i++) begin
        count_r[i] <= '0;
        total_r[i] <= '0;
        max_r[i]   <= '0;
        min_r[i]   <= '0;
      end
    end else if (upd && acc) begin
      count_r[idx] <= cnt_nxt;
      total_r[idx] <= tot_nxt;
      max_r[idx]   <= max_nxt;
      min_r[idx]   <= min_nxt;
    end
  end

  // Out-of-range sources report all zero
  always_comb begin
    result = '0;
    if (in_range) begin
      result.accepted     = acc;
      result.event_count  = cnt_nxt;
      result.duration_sum = tot_nxt;
      result.longest      = max_nxt;
      result.shortest     = min_nxt;
    end
  end

endmodule

[hdl/interrupt_duration_statistics_core.sv]
// Interrupt duration statistics: input register, statistics table and result register.
//
// Usage:
//   in_*  : one beat per event. in_tuser = request type (0 enter, 1 exit,
//           2 read; 3 acts as read), in_tdata = vector and duration.
//   out_* : one beat per input beat, in order. out_tuser = accepted flag,
//           out_tdata = count, total, longest, shortest of the selected entry
//           after the update.
//   cfg_* : APB port; register 0 (address 0) is the 8-bit source enable mask.
//           Write it only while no beat is in flight.
// Stages: two register stages, the input register then the result register; out_tvalid
//   rises when a beat moves from the input register into the result register.
// Throughput: one beat per cycle while out_tready stays high; the table read-modify-write
//   is done combinationally between the input register and the result register.
// Reset clears the enable mask, every table entry and both stage valids; the
//   block is ready in the first cycle after reset.
// When the receiver stalls, the result register holds; the input register
//   still takes one more beat, then in_tready drops until out_tready returns.
module interrupt_duration_statistics_core #(
  parameter int NUM_SOURCES = ids_pkg::DEF_NUM_SOURCES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input beat
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ids_pkg::IN_DATA_W-1:0]     in_tdata,  // [3:0] vector, [35:4] duration, [39:36] 0
  input  logic [ids_pkg::REQ_W-1:0]         in_tuser,  // [1:0] req_type
  // Result beat
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ids_pkg::OUT_DATA_W-1:0]    out_tdata, // event_count, duration_sum, longest, shortest
  output logic [0:0]                        out_tuser, // [0] accepted
  // Configuration
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [ids_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [ids_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [ids_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  logic                          in_v_r, in_v_nxt;
  ids_pkg::item_t                item_r;
  logic                          out_v_r, out_v_nxt;
  ids_pkg::result_t              res_r;
  ids_pkg::result_t              res;
  logic [ids_pkg::MASK_BITS-1:0] enable_mask;
  logic                          adv;
  logic                          fire;
  logic                          in_fire;

  ids_apb u_apb (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .enable_mask (enable_mask)
  );

  ids_stats #(
    .NUM_SOURCES (NUM_SOURCES)
  ) u_stats (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd         (fire),
    .item        (item_r),
    .enable_mask (enable_mask),
    .result      (res)
  );

  // Handshake: advance when the result register is free or being drained
  assign adv       = !out_v_r || out_tready;
  assign fire      = in_v_r && adv;
  assign in_tready = !in_v_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_fire) begin
      in_v_nxt = 1'b1;
    end else if (fire) begin
      in_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (fire) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.req_type <= in_tuser;
      item_r.vector   <= in_tdata[ids_pkg::VEC_W-1:0];
      item_r.duration <= in_tdata[ids_pkg::VEC_W +: ids_pkg::STAT_W];
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = res_r.accepted;
  assign out_tdata  = {res_r.shortest, res_r.longest, res_r.duration_sum, res_r.event_count};

  // A set shortest never exceeds the longest
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (res_r.shortest != '0)) |-> (res_r.shortest <= res_r.longest))
    else $error("shortest exceeds longest");

  // An empty result register always lets a beat in
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_tready)
    else $error("input stalled with empty result register");

  // A beat leaving the input register lands in the result register
  a_fire_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_v_r)
    else $error("result lost after advance");

endmodule

[tb/tb.sv]
// Self-checking testbench for the per-source interrupt duration statistics core.
`timescale 1ns / 100ps

module tb;

  localparam int                        NUM_SRC    = ids_pkg::DEF_NUM_SOURCES;
  localparam logic [ids_pkg::REQ_W-1:0] REQ_SPARE  = 2'd3;
  localparam int                        LONG_HOLD  = 300;
  localparam int                        DRAIN_WAIT = 6;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [ids_pkg::IN_DATA_W-1:0]  in_tdata  = '0;  // [3:0] vector, [35:4] duration, [39:36] zero
  logic [ids_pkg::REQ_W-1:0]      in_tuser  = '0;  // [1:0] req_type
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [ids_pkg::OUT_DATA_W-1:0] out_tdata;  // event_count, duration_sum, longest, shortest
  logic [0:0]                     out_tuser;  // [0] accepted
  logic                           cfg_psel    = 1'b0;
  logic                           cfg_penable = 1'b0;
  logic                           cfg_pwrite  = 1'b0;
  logic [ids_pkg::CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [ids_pkg::CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [ids_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;

  // Shadow of the statistics table and the enable mask
  logic [ids_pkg::MASK_BITS-1:0] enable_copy = '0;
  logic [ids_pkg::STAT_W-1:0]    count_copy [NUM_SRC];
  logic [ids_pkg::STAT_W-1:0]    total_copy [NUM_SRC];
  logic [ids_pkg::STAT_W-1:0]    max_copy   [NUM_SRC];
  logic [ids_pkg::STAT_W-1:0]    min_copy   [NUM_SRC];

  ids_pkg::item_t   pending_events[$];
  ids_pkg::result_t expected_entries[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic hold_request = 1'b0;
  logic hold_off     = 1'b0;

  int mismatches     = 0;
  int beats_in       = 0;
  int beats_out      = 0;
  int enters_counted = 0;
  int exits_timed    = 0;
  int reads_served   = 0;
  int beats_dropped  = 0;
  int masks_written  = 0;

  interrupt_duration_statistics_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one event to the shadow table and return the entry it selects
  function automatic ids_pkg::result_t apply_event(input logic [ids_pkg::REQ_W-1:0] req,
                                                   input logic [ids_pkg::VEC_W-1:0] vec,
                                                   input logic [ids_pkg::STAT_W-1:0] dur);
    ids_pkg::result_t entry;
    logic             hit;
    entry = '0;
    if (vec < NUM_SRC) begin
      hit = (vec < ids_pkg::MASK_BITS) ? enable_copy[vec[2:0]] : 1'b0;
      if (hit) begin
        case (req)
          ids_pkg::REQ_ENTER: begin
            count_copy[vec] = count_copy[vec] + 1;
          end
          ids_pkg::REQ_EXIT: begin
            total_copy[vec] = total_copy[vec] + dur;
            if (dur > max_copy[vec]) max_copy[vec] = dur;
            // zero stored minimum means unset
            if (dur < min_copy[vec] || min_copy[vec] == '0) min_copy[vec] = dur;
          end
          default: ;
        endcase
      end
      entry.accepted     = hit;
      entry.event_count  = count_copy[vec];
      entry.duration_sum = total_copy[vec];
      entry.longest      = max_copy[vec];
      entry.shortest     = min_copy[vec];
    end
    return entry;
  endfunction

  // Drive input beats from the pending queue; predict on each handshake
  always @(posedge clk) begin : drive_events
    ids_pkg::item_t   ev;
    ids_pkg::result_t pred;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        pred = apply_event(in_tuser, in_tdata[ids_pkg::VEC_W-1:0],
                           in_tdata[ids_pkg::VEC_W +: ids_pkg::STAT_W]);
        expected_entries.push_back(pred);
        beats_in++;
        if (!pred.accepted) beats_dropped++;
        else if (in_tuser == ids_pkg::REQ_ENTER) enters_counted++;
        else if (in_tuser == ids_pkg::REQ_EXIT) exits_timed++;
        else reads_served++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          ev = pending_events.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= ev.req_type;
          in_tdata  <= {{(ids_pkg::IN_DATA_W-ids_pkg::VEC_W-ids_pkg::STAT_W){1'b0}},
                        ev.duration, ev.vector};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [ids_pkg::STAT_W-1:0] want,
                             input logic [ids_pkg::STAT_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  // Stall the result side at random and check each result beat in order
  always @(posedge clk) begin : watch_results
    ids_pkg::result_t want;
    ids_pkg::result_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
      if (out_tvalid && out_tready) begin
        got.accepted     = out_tuser[0];
        got.event_count  = out_tdata[ids_pkg::STAT_W-1:0];
        got.duration_sum = out_tdata[2*ids_pkg::STAT_W-1:ids_pkg::STAT_W];
        got.longest      = out_tdata[3*ids_pkg::STAT_W-1:2*ids_pkg::STAT_W];
        got.shortest     = out_tdata[4*ids_pkg::STAT_W-1:3*ids_pkg::STAT_W];
        beats_out++;
        if (expected_entries.size() == 0) begin
          $error("result beat with no entry expected");
          mismatches++;
        end else begin
          want = expected_entries.pop_front();
          check_field("accepted", 32'(want.accepted), 32'(got.accepted));
          check_field("event_count", want.event_count, got.event_count);
          check_field("duration_sum", want.duration_sum, got.duration_sum);
          check_field("longest", want.longest, got.longest);
          check_field("shortest", want.shortest, got.shortest);
        end
      end
    end
  end

  // Hold the receiver off for a long stretch once requested
  initial begin : receiver_hold_off
    wait (hold_request);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic add_event(input logic [ids_pkg::REQ_W-1:0] req,
                           input logic [ids_pkg::VEC_W-1:0] vec,
                           input logic [ids_pkg::STAT_W-1:0] dur);
    ids_pkg::item_t ev;
    ev.req_type = req;
    ev.vector   = vec;
    ev.duration = dur;
    pending_events.push_back(ev);
  endtask

  task automatic add_random_event();
    logic [ids_pkg::REQ_W-1:0]  req;
    logic [ids_pkg::VEC_W-1:0]  vec;
    logic [ids_pkg::STAT_W-1:0] dur;
    int pick;
    pick = $urandom_range(99);
    if (pick < 35) req = ids_pkg::REQ_ENTER;
    else if (pick < 75) req = ids_pkg::REQ_EXIT;
    else if (pick < 92) req = ids_pkg::REQ_READ;
    else req = REQ_SPARE;
    // keep most traffic on real sources so entries accumulate
    if ($urandom_range(99) < 85) vec = 4'($urandom_range(NUM_SRC - 1));
    else vec = 4'($urandom_range(15, NUM_SRC));
    pick = $urandom_range(99);
    if (pick < 6) dur = '0;
    else if (pick < 12) dur = 32'hFFFF_FFFF - $urandom_range(3);
    else if (pick < 55) dur = $urandom_range(2000, 1);
    else dur = $urandom();
    add_event(req, vec, dur);
  endtask

  // Wait until every beat has gone through and the pipeline is empty
  task automatic wait_for_drain();
    while (pending_events.size() != 0 || in_tvalid || expected_entries.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_enable_mask(input logic [ids_pkg::MASK_BITS-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {ids_pkg::REG_ENABLE_MASK, 2'b00};
    cfg_pwdata  <= {{(ids_pkg::CFG_DATA_W-ids_pkg::MASK_BITS){1'b0}}, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    enable_copy <= value;
    masks_written++;
  endtask

  task automatic run_phase(input logic [ids_pkg::MASK_BITS-1:0] mask, input int send_pct,
                           input int recv_pct, input int beats, input logic pressure);
    write_enable_mask(mask);
    @(posedge clk);
    send_idle_pct  <= send_pct;
    recv_stall_pct <= recv_pct;
    @(negedge clk);
    if (pressure) hold_request = 1'b1;
    repeat (beats) add_random_event();
    wait_for_drain();
  endtask

  initial begin : stimulus
    for (int i = 0; i < NUM_SRC; i++) begin
      count_copy[i] = '0;
      total_copy[i] = '0;
      max_copy[i]   = '0;
      min_copy[i]   = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Mask still at reset: everything is disabled or out of range
    add_event(ids_pkg::REQ_READ,  4'd0,  32'd0);
    add_event(ids_pkg::REQ_ENTER, 4'd3,  32'd0);
    add_event(ids_pkg::REQ_EXIT,  4'd5,  32'hFFFF_FFFF);
    add_event(ids_pkg::REQ_ENTER, 4'd8,  32'd0);
    add_event(ids_pkg::REQ_EXIT,  4'd15, 32'd7);
    wait_for_drain();

    // All sources on: unset minimum, wraps, extremes and the spare code
    write_enable_mask(8'hFF);
    @(negedge clk);
    add_event(ids_pkg::REQ_ENTER, 4'd0,  32'd0);
    add_event(ids_pkg::REQ_EXIT,  4'd0,  32'd0);
    add_event(ids_pkg::REQ_EXIT,  4'd0,  32'd100);
    add_event(ids_pkg::REQ_EXIT,  4'd0,  32'd50);
    add_event(ids_pkg::REQ_EXIT,  4'd0,  32'hFFFF_FFFF);
    add_event(ids_pkg::REQ_EXIT,  4'd0,  32'd1);
    add_event(ids_pkg::REQ_READ,  4'd0,  32'hDEAD_BEEF);
    add_event(REQ_SPARE,          4'd0,  32'h1234_5678);
    add_event(ids_pkg::REQ_ENTER, 4'd7,  32'd0);
    add_event(ids_pkg::REQ_EXIT,  4'd7,  32'h8000_0000);
    add_event(ids_pkg::REQ_EXIT,  4'd7,  32'h8000_0000);
    add_event(ids_pkg::REQ_READ,  4'd7,  32'd0);
    add_event(ids_pkg::REQ_ENTER, 4'd8,  32'd0);
    add_event(ids_pkg::REQ_EXIT,  4'd15, 32'hFFFF_FFFF);
    add_event(ids_pkg::REQ_READ,  4'd9,  32'd0);
    add_event(REQ_SPARE,          4'd15, 32'd0);
    wait_for_drain();

    // Random phases across mask settings and idling patterns
    run_phase(8'hFF, 0, 0, 400, 1'b0);
    run_phase(8'($urandom_range(255)), 50, 0, 350, 1'b0);
    run_phase(8'hFF, 0, 50, 350, 1'b0);
    run_phase(8'h00, 16, 16, 100, 1'b0);
    run_phase(8'($urandom_range(255)), 16, 16, 350, 1'b0);
    run_phase(8'hFF, 0, 0, 400, 1'b1);

    wait_for_drain();
    $display("Checked %0d result beats for %0d input beats over %0d mask settings.",
             beats_out, beats_in, masks_written + 1);
    $display("Accepted %0d enters, %0d exits, %0d reads; %0d beats disabled or out of range.",
             enters_counted, exits_timed, reads_served, beats_dropped);
    if (mismatches == 0 && expected_entries.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
